### sv/reply_frame_crc_checker_unit_defines.svh
// Assertion macros shared by the reply frame CRC checker.
`ifndef REPLY_FRAME_CRC_CHECKER_UNIT_DEFINES_SVH
`define REPLY_FRAME_CRC_CHECKER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RFCC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define RFCC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define RFCC_ASSERT(lbl, prop, msg)
`define RFCC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

### sv/rfcc_pkg.sv
// Types, constants and functions of the reply frame CRC checker.
package rfcc_pkg;

    localparam int MAX_FRAME = 150;

    localparam logic [7:0]  CR_BYTE    = 8'h0d;
    localparam logic [7:0]  LF_BYTE    = 8'h0a;
    localparam logic [7:0]  START_BYTE = 8'h28;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_START = 3'd1;
    localparam logic [2:0] ST_BAD_CRC   = 3'd2;
    localparam logic [2:0] ST_SHORT     = 3'd3;
    localparam logic [2:0] ST_OVERLEN   = 3'd4;

    localparam logic [2:0] MODE_NONE = 3'd0;
    localparam logic [2:0] MODE_P    = 3'd1;
    localparam logic [2:0] MODE_S    = 3'd2;
    localparam logic [2:0] MODE_L    = 3'd3;
    localparam logic [2:0] MODE_B    = 3'd4;
    localparam logic [2:0] MODE_F    = 3'd5;
    localparam logic [2:0] MODE_H    = 3'd6;

    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } t_stage;

    typedef struct packed {
        logic       valid;
        logic [2:0] status;
        logic [7:0] length;
        logic [2:0] mode;
    } t_result;

    // One MSB-first byte update, worked bit by bit with CRC_POLY.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [7:0] bump(input logic [7:0] b);
        return (b == START_BYTE || b == CR_BYTE || b == LF_BYTE) ? b + 8'd1 : b;
    endfunction

    function automatic logic [2:0] mode_map(input logic [7:0] m);
        logic [2:0] r;
        unique case (m)
            8'h50:   r = MODE_P;
            8'h53:   r = MODE_S;
            8'h4c:   r = MODE_L;
            8'h42:   r = MODE_B;
            8'h46:   r = MODE_F;
            8'h48:   r = MODE_H;
            default: r = MODE_NONE;
        endcase
        return r;
    endfunction

endpackage

### sv/rfcc_input_reg.sv
// Input register that holds one received byte for the frame core.
module rfcc_input_reg
    import rfcc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    input  logic       i_advance,
    output logic       o_ready,
    output t_stage     o_stage
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_stage = '{valid: r_valid, rx_byte: r_byte};

endmodule

### sv/rfcc_frame_core.sv
// Frame state: running CRC, held bytes, count, start check and mode byte.
module rfcc_frame_core
    import rfcc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_stage  i_stage,
    input  logic    i_advance,
    output t_result o_result
);

    logic [15:0] r_crc, n_crc;
    logic [15:0] r_held, n_held;
    logic [7:0]  r_count, n_count;
    logic        r_start, n_start;
    logic [7:0]  r_mode, n_mode;

    logic        fire;
    logic        is_cr;
    logic        overlen;
    logic [7:0]  len;
    logic [15:0] want;

    assign fire    = i_stage.valid && i_advance;
    assign is_cr   = (i_stage.rx_byte == CR_BYTE);
    assign overlen = ({1'b0, r_count} + 9'd1) >= 9'(MAX_FRAME);
    assign len     = r_count + 8'd1;
    assign want    = {bump(r_crc[15:8]), bump(r_crc[7:0])};

    always_comb begin
        o_result.valid  = fire && (is_cr || overlen);
        o_result.length = is_cr ? len : 8'(MAX_FRAME);
        o_result.mode   = mode_map(r_mode);
        priority if (!is_cr) begin
            o_result.status = ST_OVERLEN;
        end else if (len < 8'd4) begin
            o_result.status = ST_SHORT;
        end else if (!r_start) begin
            o_result.status = ST_BAD_START;
        end else if (want == r_held) begin
            o_result.status = ST_OK;
        end else begin
            o_result.status = ST_BAD_CRC;
        end
    end

    always_comb begin
        n_crc   = r_crc;
        n_held  = r_held;
        n_count = r_count;
        n_start = r_start;
        n_mode  = r_mode;
        if (fire) begin
            if (is_cr || overlen) begin
                n_crc   = '0;
                n_held  = '0;
                n_count = '0;
                n_start = 1'b0;
                n_mode  = '0;
            end else begin
                if (r_count >= 8'd2) begin
                    n_crc = crc_byte(r_crc, r_held[15:8]);
                end
                n_held  = {r_held[7:0], i_stage.rx_byte};
                n_count = r_count + 8'd1;
                if (r_count == 8'd0) begin
                    n_start = (i_stage.rx_byte == START_BYTE);
                end
                if (r_count == 8'd1) begin
                    n_mode = i_stage.rx_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= '0;
            r_held  <= '0;
            r_count <= '0;
            r_start <= 1'b0;
            r_mode  <= '0;
        end else begin
            r_crc   <= n_crc;
            r_held  <= n_held;
            r_count <= n_count;
            r_start <= n_start;
            r_mode  <= n_mode;
        end
    end

endmodule

### sv/rfcc_result_reg.sv
// Result register that holds one frame result until the receiver takes it.
module rfcc_result_reg
    import rfcc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_advance,
    output t_result o_result
);

    logic       r_valid;
    logic [2:0] r_status;
    logic [7:0] r_length;
    logic [2:0] r_mode;

    assign o_advance = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_result.valid) begin
            r_status <= i_result.status;
            r_length <= i_result.length;
            r_mode   <= i_result.mode;
        end
    end

    assign o_result = '{valid: r_valid, status: r_status, length: r_length, mode: r_mode};

endmodule

### sv/reply_frame_crc_checker_unit.sv
// Top level of the reply frame CRC checker.
// Reply bytes enter on the input channel (i_valid, o_ready, i_rx_byte), one
// transaction per byte. A carriage return ends a frame and yields one result
// transaction on the output channel (o_valid, i_ready) carrying the status,
// the frame length including the carriage return, and the mode code taken
// from the second byte. A byte that would overrun the frame length limit
// yields an overlength result at once, is dropped, and the frame restarts.
// A byte is taken into an input register; when the result register can
// advance, the frame logic updates the CRC state and loads the result
// register. One byte is accepted every cycle while the receiver does not
// stall; the CRC update is a single byte step. When the receiver stalls,
// the result register holds and the input register takes one more byte
// only if it was empty; o_ready then stays low until the result is taken.
// Synchronous reset clears the frame state and both registers' valid flags.
`include "reply_frame_crc_checker_unit_defines.svh"
module reply_frame_crc_checker_unit
    import rfcc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_frame_status,
    output logic [7:0] o_frame_length,
    output logic [2:0] o_mode_code
);

    t_stage  stage;
    t_result core_result;
    t_result out_result;
    logic    advance;

    rfcc_input_reg u_input_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .i_advance (advance),
        .o_ready   (o_ready),
        .o_stage   (stage)
    );

    rfcc_frame_core u_frame_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_stage   (stage),
        .i_advance (advance),
        .o_result  (core_result)
    );

    rfcc_result_reg u_result_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_result  (core_result),
        .i_ready   (i_ready),
        .o_advance (advance),
        .o_result  (out_result)
    );

    assign o_valid        = out_result.valid;
    assign o_frame_status = out_result.status;
    assign o_frame_length = out_result.length;
    assign o_mode_code    = out_result.mode;

    `RFCC_ASSERT_RST(a_reset_clears, !i_rst_n |=> !o_valid, "result valid after reset")
    `RFCC_ASSERT(a_ok_len, o_valid && o_frame_status == ST_OK |-> o_frame_length >= 8'd4, "ok frame too short")
    `RFCC_ASSERT(a_overlen_len, o_valid && o_frame_status == ST_OVERLEN |-> o_frame_length == 8'(MAX_FRAME), "overlength length wrong")
    `RFCC_ASSERT(a_stage_hold, stage.valid && !advance |=> stage.valid, "held byte lost during stall")

endmodule
